// ----- design/cvk3d_pkg.sv -----
// package for the 3d constant velocity kalman filter
// types, constants and fixed point helpers; no dependencies
package cvk3d_pkg;

  localparam int VW = 32;
  localparam int FB = 16;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE = VW'(1) <<< FB;

  // register indexes
  localparam logic [2:0] REG_Q  = 3'd0;
  localparam logic [2:0] REG_P0 = 3'd1;
  localparam logic [2:0] REG_R  = 3'd2;
  localparam logic [2:0] REG_SX = 3'd3;
  localparam logic [2:0] REG_SY = 3'd4;
  localparam logic [2:0] REG_SZ = 3'd5;

  localparam logic CMD_UPDATE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
    logic [19:0]        step_time;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] est_px;
    logic signed [31:0] est_py;
    logic signed [31:0] est_pz;
    logic signed [31:0] est_vx;
    logic signed [31:0] est_vy;
    logic signed [31:0] est_vz;
  } out_req_t;

  // datapath operations issued by the controller
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_RESTART = 4'd1;
  localparam logic [3:0] OP_MUL     = 4'd2;
  localparam logic [3:0] OP_ADD     = 4'd3;
  localparam logic [3:0] OP_SUB     = 4'd4;
  localparam logic [3:0] OP_DIV     = 4'd5;
  localparam logic [3:0] OP_COPY    = 4'd6;
  localparam logic [3:0] OP_ZERO    = 4'd7;

  // register file slots of the datapath
  localparam int NSLOT = 32;
  typedef logic [4:0] slot_t;
  localparam slot_t S_PX = 5'd0, S_PY = 5'd1, S_PZ = 5'd2;
  localparam slot_t S_VX = 5'd3, S_VY = 5'd4, S_VZ = 5'd5;
  localparam slot_t S_PP = 5'd6, S_PC = 5'd7, S_PV = 5'd8;
  localparam slot_t S_D  = 5'd9, S_Q = 5'd10, S_R = 5'd11;
  localparam slot_t S_MX = 5'd12, S_MY = 5'd13, S_MZ = 5'd14;
  localparam slot_t S_PCH = 5'd15, S_PPH = 5'd16, S_PVH = 5'd17;
  localparam slot_t S_S = 5'd18, S_KP = 5'd19, S_KV = 5'd20;
  localparam slot_t S_T0 = 5'd21, S_T1 = 5'd22, S_ONE = 5'd23;
  localparam slot_t S_EX = 5'd24, S_EY = 5'd25, S_EZ = 5'd26;
  localparam slot_t S_OM = 5'd27;

  typedef struct packed {
    logic [3:0] op;
    slot_t      a;
    slot_t      b;
    slot_t      dst;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic s_pos;
  } stat_t;

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
    return s[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] sat_sub(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
    return s[VW-1:0];
  endfunction

  // magnitude result with sign to saturated value
  function automatic logic signed [VW-1:0] from_mag(input logic neg,
                                                    input logic [2*VW+FB-1:0] m);
    logic [VW:0] cap;
    logic [VW:0] v;
    cap = neg ? {1'b0, 1'b1, {(VW-1){1'b0}}} : {2'b00, {(VW-1){1'b1}}};
    if (m > {{(VW+FB-1){1'b0}}, cap}) v = cap;
    else v = m[VW:0];
    return neg ? VW'(-v) : v[VW-1:0];
  endfunction

endpackage

// ----- design/cvk3d_ctrl.sv -----
// sequencer for the kalman update: issues one datapath operation per step
// depends on cvk3d_pkg
module cvk3d_ctrl import cvk3d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_cmd,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  load,
  output cmd_t  dcmd,
  input  stat_t dstat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  localparam int NSTEP = 40;
  logic [1:0] state, state_next;
  logic [5:0] pc, pc_next;
  logic       out_valid_next;
  cmd_t       prog;

  // microprogram
  always_comb begin
    prog = '{OP_NONE, S_PX, S_PX, S_PX};
    case (pc)
      6'd0:  prog = '{OP_MUL,  S_D,   S_PV,  S_T0};
      6'd1:  prog = '{OP_ADD,  S_PC,  S_T0,  S_PCH};
      6'd2:  prog = '{OP_MUL,  S_D,   S_PC,  S_T0};
      6'd3:  prog = '{OP_ADD,  S_PP,  S_T0,  S_T0};
      6'd4:  prog = '{OP_MUL,  S_D,   S_PCH, S_T1};
      6'd5:  prog = '{OP_ADD,  S_T0,  S_T1,  S_T0};
      6'd6:  prog = '{OP_ADD,  S_T0,  S_Q,   S_PPH};
      6'd7:  prog = '{OP_ADD,  S_PV,  S_Q,   S_PVH};
      6'd8:  prog = '{OP_ADD,  S_PPH, S_R,   S_S};
      6'd9:  prog = '{OP_DIV,  S_PPH, S_S,   S_KP};
      6'd10: prog = '{OP_DIV,  S_PCH, S_S,   S_KV};
      6'd11: prog = '{OP_MUL,  S_D,   S_VX,  S_T0};
      6'd12: prog = '{OP_ADD,  S_PX,  S_T0,  S_PX};
      6'd13: prog = '{OP_SUB,  S_MX,  S_PX,  S_EX};
      6'd14: prog = '{OP_MUL,  S_D,   S_VY,  S_T0};
      6'd15: prog = '{OP_ADD,  S_PY,  S_T0,  S_PY};
      6'd16: prog = '{OP_SUB,  S_MY,  S_PY,  S_EY};
      6'd17: prog = '{OP_MUL,  S_D,   S_VZ,  S_T0};
      6'd18: prog = '{OP_ADD,  S_PZ,  S_T0,  S_PZ};
      6'd19: prog = '{OP_SUB,  S_MZ,  S_PZ,  S_EZ};
      6'd20: prog = '{OP_MUL,  S_KP,  S_EX,  S_T0};
      6'd21: prog = '{OP_ADD,  S_PX,  S_T0,  S_PX};
      6'd22: prog = '{OP_MUL,  S_KV,  S_EX,  S_T0};
      6'd23: prog = '{OP_ADD,  S_VX,  S_T0,  S_VX};
      6'd24: prog = '{OP_MUL,  S_KP,  S_EY,  S_T0};
      6'd25: prog = '{OP_ADD,  S_PY,  S_T0,  S_PY};
      6'd26: prog = '{OP_MUL,  S_KV,  S_EY,  S_T0};
      6'd27: prog = '{OP_ADD,  S_VY,  S_T0,  S_VY};
      6'd28: prog = '{OP_MUL,  S_KP,  S_EZ,  S_T0};
      6'd29: prog = '{OP_ADD,  S_PZ,  S_T0,  S_PZ};
      6'd30: prog = '{OP_MUL,  S_KV,  S_EZ,  S_T0};
      6'd31: prog = '{OP_ADD,  S_VZ,  S_T0,  S_VZ};
      6'd32: prog = '{OP_SUB,  S_ONE, S_KP,  S_OM};
      6'd33: prog = '{OP_MUL,  S_OM,  S_PPH, S_PP};
      6'd34: prog = '{OP_MUL,  S_OM,  S_PCH, S_PC};
      6'd35: prog = '{OP_MUL,  S_KV,  S_PCH, S_T0};
      6'd36: prog = '{OP_SUB,  S_PVH, S_T0,  S_PV};
      default: prog = '{OP_NONE, S_PX, S_PX, S_PX};
    endcase
    // gains are zero when the innovation variance is not positive
    if ((pc == 6'd9 || pc == 6'd10) && !dstat.s_pos) prog.op = OP_ZERO;
  end

  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    pc_next = pc;
    out_valid_next = out_valid && !out_ready;
    load = 1'b0;
    dcmd = '{OP_NONE, S_PX, S_PX, S_PX};
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          load = 1'b1;
          if (in_cmd == CMD_RESTART) begin
            dcmd.op = OP_RESTART;
          end else begin
            state_next = ST_RUN;
            pc_next = '0;
          end
        end
      end
      ST_RUN: begin
        dcmd = prog;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (!dstat.busy) begin
          if (pc == 6'(NSTEP - 4)) begin
            state_next = ST_IDLE;
            out_valid_next = 1'b1;
          end else begin
            pc_next = pc + 6'd1;
            state_next = ST_RUN;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/cvk3d_dp.sv -----
// datapath: register file, shared multiplier, adder and serial divider
// depends on cvk3d_pkg
module cvk3d_dp import cvk3d_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  in_req_t  in_data,
  input  cmd_t     dcmd,
  output stat_t    dstat,
  input  logic     cfg_valid,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  output out_req_t out_data
);

  localparam int DW = 2 * VW + FB; // width of the divide numerator
  logic signed [VW-1:0] rf [NSLOT];
  logic [30:0] reg_q, reg_p0, reg_r;
  logic signed [31:0] reg_sx, reg_sy, reg_sz;

  logic signed [VW-1:0] a, b;
  assign a = rf[dcmd.a];
  assign b = rf[dcmd.b];

  // multiplier, combinational, result written into the register file
  logic [VW-1:0] ma, mb;
  logic [2*VW-1:0] mprod;
  logic [2*VW:0] mrnd;
  logic signed [VW-1:0] mres;
  assign ma = a[VW-1] ? VW'(-a) : a;
  assign mb = b[VW-1] ? VW'(-b) : b;
  assign mprod = ma * mb;
  assign mrnd = {1'b0, mprod} + (2*VW+1)'(1 << (FB - 1));
  assign mres = from_mag(a[VW-1] ^ b[VW-1], DW'(mrnd >> FB));

  // serial restoring divider, one quotient bit per cycle
  logic         dbusy;
  logic [6:0]   dcnt;
  logic [DW-1:0] dnum, dquo;
  logic [VW:0]  drem;
  logic [VW-1:0] dden;
  logic         dneg;
  slot_t        ddst;
  logic [VW:0]  rsh;
  logic         dfit;

  assign rsh  = {drem[VW-1:0], dnum[DW-1]};
  assign dfit = rsh >= {1'b0, dden};

  assign dstat.busy  = dbusy;
  assign dstat.s_pos = !rf[S_S][VW-1] && (rf[S_S] != '0);

  logic [DW-1:0] qfin;
  logic [VW:0]   dtwice;
  assign dtwice = {1'b0, dden} - drem;
  assign qfin = dquo + DW'(drem >= dtwice);

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt <= '0;
      reg_q <= 31'd655360;
      reg_p0 <= 31'd655360000;
      reg_r <= 31'd1310720;
      reg_sx <= '0;
      reg_sy <= '0;
      reg_sz <= '0;
      for (int i = 0; i < 6; i++) rf[i] <= '0;
      rf[S_PP] <= VW'(31'd655360000);
      rf[S_PV] <= VW'(31'd655360000);
      rf[S_PC] <= '0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          REG_Q:  reg_q <= cfg_data[30:0];
          REG_P0: reg_p0 <= cfg_data[30:0];
          REG_R:  reg_r <= cfg_data[30:0];
          REG_SX: reg_sx <= cfg_data;
          REG_SY: reg_sy <= cfg_data;
          REG_SZ: reg_sz <= cfg_data;
          default: ;
        endcase
      end
      // request capture
      if (load) begin
        rf[S_MX] <= in_data.meas_x;
        rf[S_MY] <= in_data.meas_y;
        rf[S_MZ] <= in_data.meas_z;
        rf[S_D]  <= VW'(in_data.step_time);
        rf[S_Q]  <= VW'(reg_q);
        rf[S_R]  <= VW'(reg_r);
        rf[S_ONE] <= ONE;
      end
      case (dcmd.op)
        OP_RESTART: begin
          rf[S_PX] <= reg_sx;
          rf[S_PY] <= reg_sy;
          rf[S_PZ] <= reg_sz;
          rf[S_VX] <= '0;
          rf[S_VY] <= '0;
          rf[S_VZ] <= '0;
          rf[S_PP] <= VW'(reg_p0);
          rf[S_PV] <= VW'(reg_p0);
          rf[S_PC] <= '0;
        end
        OP_MUL:  rf[dcmd.dst] <= mres;
        OP_ADD:  rf[dcmd.dst] <= sat_add(a, b);
        OP_SUB:  rf[dcmd.dst] <= sat_sub(a, b);
        OP_COPY: rf[dcmd.dst] <= a;
        OP_ZERO: rf[dcmd.dst] <= '0;
        OP_DIV: begin
          dbusy <= 1'b1;
          dcnt <= 7'(DW);
          dnum <= DW'(ma) << FB;
          dquo <= '0;
          drem <= '0;
          dden <= b;
          dneg <= a[VW-1];
          ddst <= dcmd.dst;
        end
        default: ;
      endcase
      // divider iteration
      if (dbusy) begin
        if (dcnt == '0) begin
          dbusy <= 1'b0;
          rf[ddst] <= from_mag(dneg, qfin);
        end else begin
          dcnt <= dcnt - 7'd1;
          dnum <= dnum << 1;
          dquo <= {dquo[DW-2:0], dfit};
          drem <= dfit ? rsh - {1'b0, dden} : rsh;
        end
      end
    end
  end

  assign out_data = '{rf[S_PX], rf[S_PY], rf[S_PZ], rf[S_VX], rf[S_VY], rf[S_VZ]};

endmodule

// ----- design/constant_velocity_kalman_3d_top.sv -----
// top level of the 3d constant velocity kalman filter
// depends on cvk3d_pkg, cvk3d_ctrl, cvk3d_dp
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_req_t
// out      output     out_valid / out_ready  out_req_t
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an update offers its result once the microprogram has run, two of its steps being
// serial divides (issue, 80 quotient bits, round, release)
// with the innovation variance not positive the gains are zeroed and no divide runs
// a restart request is applied in the cycle it is taken and gives no result
// the next request is taken only once the result has been collected
// rst is synchronous and reloads the start state and register reset values
module constant_velocity_kalman_3d_top import cvk3d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_req_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_req_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  logic  load;
  cmd_t  dcmd;
  stat_t dstat;

  assign cfg_ready = 1'b1;

  cvk3d_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_data.cmd), .out_valid(out_valid), .out_ready(out_ready),
    .load(load), .dcmd(dcmd), .dstat(dstat)
  );

  cvk3d_dp u_dp (
    .clk(clk), .rst(rst), .load(load), .in_data(in_data), .dcmd(dcmd),
    .dstat(dstat), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_data(out_data)
  );

  // no new request while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while result pending");

  // a restart gives no result
  a_restart_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.cmd == CMD_RESTART) |=> !out_valid)
    else $error("restart produced a result");

  // result held under stall
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

endmodule
